>>> rtl/core/tcg_pkg.sv
// tcg_pkg: shared types and constants for the text mode character generator
`timescale 1ns / 1ps

package tcg_pkg;

    localparam int CELL_HEIGHT_DEF = 16;
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_GLYPH   = 2'd0,
        CMD_LOAD_PALETTE = 2'd1,
        CMD_RENDER       = 2'd2
    } cmd_t;

    typedef logic [23:0] color_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [3:0] glyph_row;
        logic [7:0] glyph_byte;
        logic [3:0] palette_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } item_word_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
    } pixel_word_t;

    typedef struct packed {
        color_t     fore;
        color_t     back;
        logic [7:0] bits;
        logic       line_char;
    } render_job_t;

    localparam color_t DEFAULT_COLORS [16] = '{
        24'h000000, 24'h0000FF, 24'h008B00, 24'h008B8B,
        24'h8B0000, 24'h8B008B, 24'hFF4040, 24'hD3D3D3,
        24'hA9A9A9, 24'hADD8E6, 24'h90EE90, 24'hE0FFFF,
        24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
    };

endpackage

>>> rtl/core/text_mode_character_generator.sv
// text_mode_character_generator: top level of the text mode character generator
//
// item channel (item_valid, item_stall, item): glyph loads, palette loads and
// render words. a word is taken when item_valid is high and item_stall low.
// loads give no pixels; a render gives 8 or 9 pixels.
// pixel channel (pixel_valid, pixel_stall, pixel): one pixel word per cycle while
// pixel_stall is low; last_pixel marks the final pixel of the cell scanline.
// cfg channel (cfg_valid, cfg_ready, cfg_data): nine_pixel_mode, always ready.
// a render word passes the fetch stage, the job queue and the pixel register
// before its first pixel is valid. the pixel counter in the back end paces
// each render; render words are still taken while the back end is busy and
// wait in a two-deep job queue.
// stalling the pixel channel holds the pixel word; once the queue and the
// fetch stage are full, item_stall rises.
// reset: palette returns to its sixteen default colours, nine-pixel mode is
// set, no pixels are pending. the glyph store holds no defined value until
// written.
`timescale 1ns / 1ps

module text_mode_character_generator import tcg_pkg::*; #(
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_word_t  item,
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output pixel_word_t pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic        nine_pixel_mode_reg;
    logic        nine_pixel_mode_next;
    logic        job_push;
    render_job_t job_in;
    logic        job_full;
    logic        job_pop;
    render_job_t job_head;
    logic        job_head_valid;

    assign cfg_ready            = 1'b1;
    assign nine_pixel_mode_next = (cfg_valid && cfg_ready) ? cfg_data : nine_pixel_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nine_pixel_mode_reg <= 1'b1;
        end
        else
        begin
            nine_pixel_mode_reg <= nine_pixel_mode_next;
        end
    end

    tcg_front #(
        .CELL_HEIGHT (CELL_HEIGHT),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .job_push   (job_push),
        .job        (job_in),
        .job_full   (job_full)
    );

    tcg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job_in),
        .full       (job_full),
        .pop        (job_pop),
        .head       (job_head),
        .head_valid (job_head_valid)
    );

    tcg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .nine_pixel_mode (nine_pixel_mode_reg),
        .job             (job_head),
        .job_valid       (job_head_valid),
        .job_pop         (job_pop),
        .pixel_valid     (pixel_valid),
        .pixel_stall     (pixel_stall),
        .pixel           (pixel)
    );

endmodule

>>> rtl/core/tcg_front.sv
// tcg_front: accepts words, runs loads, reads glyph and palette for renders
`timescale 1ns / 1ps

module tcg_front import tcg_pkg::*; #(
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_word_t  item,
    output logic        job_push,
    output render_job_t job,
    input  logic        job_full
);

    localparam int GlyphDepth = GLYPH_COUNT * CELL_HEIGHT;
    localparam int AddrW      = $clog2(GlyphDepth);
    localparam logic [7:0] LineCharFirst = 8'hBF;
    localparam logic [7:0] LineCharLast  = 8'hDF;

    logic [7:0]       glyph_mem [GlyphDepth];
    color_t           pal_mem   [16];

    logic             accept;
    logic             is_render;
    logic             glyph_we;
    logic             pal_we;
    logic             glyph_ok;
    logic [AddrW-1:0] glyph_addr;
    logic [7:0]       attr_perm;
    logic [3:0]       fg_idx;
    logic [3:0]       bg_idx;

    logic [15:0]      pal_valid_reg;
    logic [15:0]      pal_valid_next;
    logic             b_valid_reg;
    logic             b_valid_next;

    logic [7:0]       glyph_q_reg;
    color_t           fg_q_reg;
    color_t           bg_q_reg;
    logic [3:0]       fg_idx_reg;
    logic [3:0]       bg_idx_reg;
    logic             fg_set_reg;
    logic             bg_set_reg;
    logic             glyph_ok_reg;
    logic             line_char_reg;

    assign accept    = item_valid && !item_stall;
    assign is_render = accept && (item.cmd == CMD_RENDER);
    assign glyph_we  = accept && (item.cmd == CMD_LOAD_GLYPH) && glyph_ok;
    assign pal_we    = accept && (item.cmd == CMD_LOAD_PALETTE);

    // swap bits 0 and 2 in each nibble
    assign attr_perm = {item.attribute[7], item.attribute[4], item.attribute[5],
                        item.attribute[6], item.attribute[3], item.attribute[0],
                        item.attribute[1], item.attribute[2]};
    assign fg_idx    = attr_perm[3:0];
    assign bg_idx    = attr_perm[7:4];

    assign glyph_ok   = (int'(item.glyph_row) < CELL_HEIGHT)
                     && (int'(item.char_code) < GLYPH_COUNT);
    assign glyph_addr = AddrW'(int'(item.char_code) * CELL_HEIGHT + int'(item.glyph_row));

    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[glyph_addr] <= item.glyph_byte;
        end
        if (is_render && glyph_ok)
        begin
            glyph_q_reg <= glyph_mem[glyph_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[item.palette_index] <= {item.red_in, item.green_in, item.blue_in};
        end
        if (is_render)
        begin
            fg_q_reg <= pal_mem[fg_idx];
            bg_q_reg <= pal_mem[bg_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_render)
        begin
            fg_idx_reg    <= fg_idx;
            bg_idx_reg    <= bg_idx;
            fg_set_reg    <= pal_valid_reg[fg_idx];
            bg_set_reg    <= pal_valid_reg[bg_idx];
            glyph_ok_reg  <= glyph_ok;
            line_char_reg <= (item.char_code >= LineCharFirst)
                          && (item.char_code <= LineCharLast);
        end
    end

    always_comb
    begin
        pal_valid_next = pal_valid_reg;
        if (pal_we)
        begin
            pal_valid_next[item.palette_index] = 1'b1;
        end
    end

    always_comb
    begin
        priority if (is_render)
        begin
            b_valid_next = 1'b1;
        end
        else if (job_push)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            pal_valid_reg <= pal_valid_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    // unwritten palette entries read as their default colour
    assign job.fore      = fg_set_reg ? fg_q_reg : DEFAULT_COLORS[fg_idx_reg];
    assign job.back      = bg_set_reg ? bg_q_reg : DEFAULT_COLORS[bg_idx_reg];
    assign job.bits      = glyph_ok_reg ? glyph_q_reg : 8'h00;
    assign job.line_char = line_char_reg;

    assign job_push   = b_valid_reg && !job_full;
    assign item_stall = b_valid_reg && job_full;

endmodule

>>> rtl/core/tcg_queue.sv
// tcg_queue: short queue of render jobs between front and back
`timescale 1ns / 1ps

module tcg_queue import tcg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  render_job_t push_job,
    output logic        full,
    input  logic        pop,
    output render_job_t head,
    output logic        head_valid
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    render_job_t     entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/tcg_back.sv
// tcg_back: expands the head render job into pixels, one a cycle while the pixel channel is not stalled
`timescale 1ns / 1ps

module tcg_back import tcg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        nine_pixel_mode,
    input  render_job_t job,
    input  logic        job_valid,
    output logic        job_pop,
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output pixel_word_t pixel
);

    localparam logic [3:0] LastNine  = 4'd8;
    localparam logic [3:0] LastEight = 4'd7;

    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        pixel_valid_reg;
    logic        pixel_valid_next;
    pixel_word_t pixel_reg;
    pixel_word_t pixel_next;

    logic        out_adv;
    logic        emit;
    logic        is_last;
    logic        use_fore;
    color_t      color;

    assign out_adv = !pixel_valid_reg || !pixel_stall;
    assign emit    = out_adv && job_valid;
    assign is_last = (cnt_reg == (nine_pixel_mode ? LastNine : LastEight));
    assign job_pop = emit && is_last;

    // ninth column repeats bit 0 only for line drawing codes
    assign use_fore = (cnt_reg == LastNine) ? (job.line_char && job.bits[0])
                                            : job.bits[~cnt_reg[2:0]];
    assign color    = use_fore ? job.fore : job.back;

    always_comb
    begin
        pixel_next            = pixel_reg;
        pixel_next.red_out    = color[23:16];
        pixel_next.green_out  = color[15:8];
        pixel_next.blue_out   = color[7:0];
        pixel_next.last_pixel = is_last;
    end

    always_comb
    begin
        cnt_next         = cnt_reg;
        pixel_valid_next = pixel_valid_reg;
        if (emit)
        begin
            cnt_next         = is_last ? '0 : cnt_reg + 1'b1;
            pixel_valid_next = 1'b1;
        end
        else if (out_adv)
        begin
            pixel_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_reg <= pixel_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg         <= cnt_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

endmodule

>>> rtl/core/tcg_checker.sv
// tcg_checker: port level assertions for the text mode character generator
`timescale 1ns / 1ps

module tcg_checker import tcg_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        item_stall,
    input logic        pixel_valid,
    input logic        pixel_stall,
    input pixel_word_t pixel
);

    // no pixel is offered in the cycle after reset is seen
    assert property (@(posedge clk) !rst_n |=> !pixel_valid)
        else $error("pixel valid during reset");

    // a stalled pixel word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("stalled pixel word changed");

    // pixels of one scanline follow without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && !pixel.last_pixel |=> pixel_valid)
        else $error("gap inside a cell scanline");

    // input only stalls when pixels are backed up
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> pixel_valid)
        else $error("input stalled with no pixel pending");

endmodule

bind text_mode_character_generator tcg_checker u_tcg_checker (.*);
